### rtl/core/dtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta timer queue package
// Sizes, opcodes and the entry type shared by the timer queue core.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int TIME_BITS   = 16;
  localparam int PROC_BITS   = 4;

  // Entry index width and the width of a count that can hold QUEUE_DEPTH.
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic [PROC_BITS-1:0] proc;
    logic [TIME_BITS-1:0] delta;
  } entry_t;

endpackage

### rtl/core/delta_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta timer queue core
// Sorted delta-list timer queue with a sequencer that walks an entry memory with
// one write port and one read port through a single shared subtractor.
// ----------------------------------------------------------------------------
// Operation: a tick reads the head entry and, when it wakes, moves each later entry up one
//   place. An insert walks the list to its place; away from the tail it moves the later
//   entries back, and the entry that stops the walk is read twice.
// Throughput: one transaction at a time; the input stalls until the result is handed to
//   the output register. A full-queue insert or an empty-queue tick goes straight to the result state.
// Reset: rst_ni clears the sequencer, the count and the output valid, not the entry memory.
// ----------------------------------------------------------------------------
module delta_timer_queue_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [dtq_pkg::PROC_BITS-1:0] proc_id_i,
  input  logic [dtq_pkg::TIME_BITS-1:0] delay_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          woke_o,
  output logic [dtq_pkg::PROC_BITS-1:0] woken_proc_o,
  output logic                          rejected_o
);

  localparam int TB = dtq_pkg::TIME_BITS;
  localparam int IW = dtq_pkg::IDX_W;
  localparam int CW = dtq_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_RM_RD,
    ST_RM_WR,
    ST_RESP
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 count_q;
  logic [IW-1:0]                 idx_q;   // memory read address
  logic [IW-1:0]                 pos_q;   // insert position found by the walk
  logic [IW-1:0]                 sh_q;    // entry being written by a move
  logic [TB-1:0]                 remain_q;
  logic [dtq_pkg::PROC_BITS-1:0] pid_q;

  // Result waiting for the output register.
  logic                          p_woke_q;
  logic [dtq_pkg::PROC_BITS-1:0] p_proc_q;
  logic                          p_rej_q;

  logic                          out_valid_q;
  logic                          woke_q;
  logic [dtq_pkg::PROC_BITS-1:0] woken_proc_q;
  logic                          rejected_q;

  // Entry memory with one write port and one registered read port.
  dtq_pkg::entry_t mem_q [dtq_pkg::QUEUE_DEPTH];
  dtq_pkg::entry_t rd_data_q;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  dtq_pkg::entry_t mem_wd;

  // Shared subtractor: one extra bit gives the borrow, which doubles as the
  // compare for the walk.
  logic [TB-1:0] alu_a, alu_b;
  logic [TB:0]   alu_diff;
  logic          alu_ge;

  logic in_accept;
  logic out_free;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    alu_a = remain_q;
    alu_b = rd_data_q.delta;
    case (state_q)
      ST_SH_WR: begin
        // The entry that ends up right behind the new one is lowered.
        alu_a = rd_data_q.delta;
        alu_b = remain_q;
      end
      ST_TICK_CHK: begin
        alu_a = rd_data_q.delta;
        alu_b = TB'(1);
      end
      default: begin
        alu_a = remain_q;
        alu_b = rd_data_q.delta;
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[TB];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sh_q;
    mem_wd = rd_data_q;
    case (state_q)
      ST_SH_WR: begin
        mem_we = 1'b1;
        mem_wa = sh_q;
        if (sh_q == pos_q + IW'(1)) begin
          mem_wd.delta = alu_diff[TB-1:0];
        end
      end
      ST_INS_WR: begin
        mem_we       = 1'b1;
        mem_wa       = pos_q;
        mem_wd.proc  = pid_q;
        mem_wd.delta = remain_q;
      end
      ST_TICK_CHK: begin
        mem_we       = (rd_data_q.delta != '0);
        mem_wa       = '0;
        mem_wd.delta = alu_diff[TB-1:0];
      end
      ST_RM_WR: begin
        mem_we = 1'b1;
        mem_wa = sh_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[idx_q];
  end

  // Sequencer, entry count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      sh_q         <= '0;
      remain_q     <= '0;
      pid_q        <= '0;
      p_woke_q     <= 1'b0;
      p_proc_q     <= '0;
      p_rej_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      woke_q       <= 1'b0;
      woken_proc_q <= '0;
      rejected_q   <= 1'b0;
    end else begin
      // A result taken while a new one is loaded is handled in ST_RESP.
      if (out_valid_q && !out_stall_i && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            pid_q    <= proc_id_i;
            remain_q <= delay_i;
            pos_q    <= '0;
            idx_q    <= '0;
            p_woke_q <= 1'b0;
            p_proc_q <= '0;
            p_rej_q  <= 1'b0;
            if (opcode_i == dtq_pkg::OP_INSERT) begin
              if (count_q == CW'(dtq_pkg::QUEUE_DEPTH)) begin
                p_rej_q <= 1'b1;
                state_q <= ST_RESP;
              end else if (count_q == '0) begin
                state_q <= ST_INS_WR;
              end else begin
                state_q <= ST_WALK_RD;
              end
            end else if (count_q == '0) begin
              state_q <= ST_RESP;
            end else begin
              state_q <= ST_TICK_RD;
            end
          end
        end
        ST_WALK_RD: begin
          state_q <= ST_WALK_CMP;
        end
        ST_WALK_CMP: begin
          if (alu_ge) begin
            // Equal expiry times go behind existing entries.
            remain_q <= alu_diff[TB-1:0];
            pos_q    <= pos_q + IW'(1);
            idx_q    <= pos_q + IW'(1);
            if (CW'(pos_q) + CW'(1) == count_q) begin
              state_q <= ST_INS_WR;
            end else begin
              state_q <= ST_WALK_RD;
            end
          end else begin
            sh_q    <= count_q[IW-1:0];
            idx_q   <= count_q[IW-1:0] - IW'(1);
            state_q <= ST_SH_RD;
          end
        end
        ST_SH_RD: begin
          state_q <= ST_SH_WR;
        end
        ST_SH_WR: begin
          if (sh_q == pos_q + IW'(1)) begin
            state_q <= ST_INS_WR;
          end else begin
            sh_q    <= sh_q - IW'(1);
            idx_q   <= sh_q - IW'(2);
            state_q <= ST_SH_RD;
          end
        end
        ST_INS_WR: begin
          count_q <= count_q + CW'(1);
          state_q <= ST_RESP;
        end
        ST_TICK_RD: begin
          state_q <= ST_TICK_CHK;
        end
        ST_TICK_CHK: begin
          if (rd_data_q.delta == '0) begin
            p_woke_q <= 1'b1;
            p_proc_q <= rd_data_q.proc;
            if (count_q == CW'(1)) begin
              count_q <= '0;
              state_q <= ST_RESP;
            end else begin
              sh_q    <= '0;
              idx_q   <= IW'(1);
              state_q <= ST_RM_RD;
            end
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RM_RD: begin
          state_q <= ST_RM_WR;
        end
        ST_RM_WR: begin
          if (CW'(sh_q) + CW'(2) == count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= ST_RESP;
          end else begin
            sh_q    <= sh_q + IW'(1);
            idx_q   <= sh_q + IW'(2);
            state_q <= ST_RM_RD;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            woke_q       <= p_woke_q;
            woken_proc_q <= p_proc_q;
            rejected_q   <= p_rej_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign woke_o       = woke_q;
  assign woken_proc_o = woken_proc_q;
  assign rejected_o   = rejected_q;

  // An accepted transaction always leaves the sequencer busy in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after an accepted transaction");

  // A result never reports a wake and a rejection together.
  a_woke_rej_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(woke_o && rejected_o))
    else $error("wake and reject reported together");

  // The entry count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (count_q <= CW'(dtq_pkg::QUEUE_DEPTH)))
    else $error("entry count beyond queue depth");

  // The count only moves by one step per transaction, and only in ST_INS_WR, ST_TICK_CHK or ST_RM_WR.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == ST_INS_WR || $past(state_q) == ST_TICK_CHK ||
       $past(state_q) == ST_RM_WR))
    else $error("entry count changed outside an update step");

endmodule
